// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("implication check failed");

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

// ----- hw/rtl/psc_pkg.sv -----
`default_nettype none
package psc_pkg;
	localparam int DataW   = 32;
	localparam int TimeW   = 20;
	localparam int IntegW  = 48;
	localparam int OpW     = 33;
	localparam int ProdW   = 66;
	localparam int AccW    = 84;
	localparam int DivW    = 53;
	localparam int DivCntW = 6;
	localparam int IdxW    = 3;
	localparam logic [TimeW-1:0] DtDefault = 20'd1049;

	typedef enum logic [IdxW-1:0] {
		REG_PROP   = 3'd0,
		REG_INTEG  = 3'd1,
		REG_DERIV  = 3'd2,
		REG_FF_POS = 3'd3,
		REG_FF_NEG = 3'd4,
		REG_DMAX   = 3'd5,
		REG_DMIN   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MS_IDT   = 3'd0,
		MS_FF    = 3'd1,
		MS_PROP  = 3'd2,
		MS_IH    = 3'd3,
		MS_IL    = 3'd4,
		MS_DERIV = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic signed [DataW-1:0] prop;
		logic signed [DataW-1:0] integ;
		logic signed [DataW-1:0] deriv;
		logic signed [DataW-1:0] ff_pos;
		logic signed [DataW-1:0] ff_neg;
		logic signed [DataW-1:0] dmax;
		logic signed [DataW-1:0] dmin;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     calc_err;
		logic     mul_en;
		mul_sel_t sel;
		logic     acc_en;
		logic     integ_upd;
		logic     div_init;
		logic     div_step;
		logic     deriv_load;
		logic     clamp;
		logic     finish;
	} psc_cmd_t;

	typedef struct packed {
		logic target_zero;
		logic last_valid;
	} psc_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pid_speed_controller_ff_top.sv -----
// Speed PID controller with sign-selected feedforward, Q16.16 throughout. Each transfer on the
// input channel brings a target speed, a measured speed and a Q0.20 time step (zero is taken
// as 1049, about 1 ms), and yields exactly one drive value on the output channel. A zero
// target clears the integral and the stored error and returns a drive of zero without
// clamping. One item at a time is worked on; a non-zero target spends most of its time in
// the one-bit-per-cycle divider that forms the derivative (53 steps, skipped on the first
// sample after a clear). A single shared 33 by 33 multiplier forms the six products in turn.
// A result waiting in the output register does not stop the next item from being taken in.
// The gains and the drive limits are to be written through the plain register port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module pid_speed_controller_ff_top
	import psc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [IdxW-1:0]         cfg_index,
	input  wire logic [DataW-1:0]        cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [DataW-1:0] speed_ref,
	input  wire logic signed [DataW-1:0] speed_fb,
	input  wire logic        [TimeW-1:0] step_time,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [DataW-1:0]      drive
);
	cfg_t      cfg_q;
	psc_cmd_t  cmd;
	psc_stat_t stat;

	// Configuration registers; a write to an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{prop: '0, integ: '0, deriv: '0, ff_pos: '0, ff_neg: '0,
			           dmax: {1'b0, {(DataW-1){1'b1}}}, dmin: {1'b1, {(DataW-1){1'b0}}}};
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP:   cfg_q.prop   <= cfg_wdata;
				REG_INTEG:  cfg_q.integ  <= cfg_wdata;
				REG_DERIV:  cfg_q.deriv  <= cfg_wdata;
				REG_FF_POS: cfg_q.ff_pos <= cfg_wdata;
				REG_FF_NEG: cfg_q.ff_neg <= cfg_wdata;
				REG_DMAX:   cfg_q.dmax   <= cfg_wdata;
				REG_DMIN:   cfg_q.dmin   <= cfg_wdata;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	psc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.speed_ref (speed_ref),
		.speed_fb  (speed_fb),
		.step_time (step_time),
		.cmd       (cmd),
		.stat      (stat),
		.drive     (drive)
	);

	// Once an item has been taken in, the block is busy with it on the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// A result never appears on the cycle straight after a transfer in.
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))
	// A new result is only loaded once the previous one has been taken or the register is empty.
	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.finish, !out_valid || out_ready)
endmodule
`default_nettype wire

// ----- hw/rtl/psc_ctrl.sv -----
`default_nettype none
module psc_ctrl
	import psc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  psc_stat_t stat,
	output psc_cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ERR   = 10'b0000000010,
		S_IMUL  = 10'b0000000100,
		S_IUPD  = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_DERIV = 10'b0000100000,
		S_MUL   = 10'b0001000000,
		S_ACC   = 10'b0010000000,
		S_CLAMP = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	localparam logic [2:0] LastTerm = 3'd4;

	state_t state_q, state_d;
	logic [DivCntW-1:0] cnt_q, cnt_d;
	logic [2:0] term_q, term_d;
	logic out_valid_q;
	mul_sel_t term_sel;

	always_comb begin
		unique case (term_q)
			3'd0:    term_sel = MS_FF;
			3'd1:    term_sel = MS_PROP;
			3'd2:    term_sel = MS_IH;
			3'd3:    term_sel = MS_IL;
			default: term_sel = MS_DERIV;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		term_d   = term_q;
		cmd      = '0;
		cmd.sel  = term_sel;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ERR;
				end
			end
			S_ERR: begin
				if (stat.target_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.calc_err = 1'b1;
					state_d      = S_IMUL;
				end
			end
			S_IMUL: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = MS_IDT;
				state_d    = S_IUPD;
			end
			S_IUPD: begin
				cmd.integ_upd = 1'b1;
				cmd.div_init  = 1'b1;
				cnt_d         = '0;
				state_d       = stat.last_valid ? S_DIV : S_DERIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivW - 1)) begin
					state_d = S_DERIV;
				end
			end
			S_DERIV: begin
				cmd.deriv_load = 1'b1;
				term_d         = '0;
				state_d        = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc_en = 1'b1;
				term_d     = term_q + 1'b1;
				state_d    = (term_q == LastTerm) ? S_CLAMP : S_MUL;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			term_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			term_q  <= term_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- hw/rtl/psc_dp.sv -----
`default_nettype none
module psc_dp
	import psc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  cfg_t                         cfg,
	input  wire logic signed [DataW-1:0] speed_ref,
	input  wire logic signed [DataW-1:0] speed_fb,
	input  wire logic        [TimeW-1:0] step_time,
	input  psc_cmd_t                     cmd,
	output psc_stat_t                    stat,
	output logic signed [DataW-1:0]      drive
);
	logic signed [DataW-1:0]  tgt_q, meas_q, err_q, last_err_q, deriv_q, res_q, drive_q;
	logic        [TimeW-1:0]  dt_q;
	logic signed [OpW-1:0]    diff_q;
	logic signed [IntegW-1:0] integ_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [AccW-1:0]   acc_q;
	logic        [DivW-1:0]   num_q;
	logic        [TimeW-1:0]  rem_q;
	logic                     dneg_q, last_valid_q;

	logic signed [OpW-1:0]    dd, op_a, op_b;
	logic signed [DataW-1:0]  err_c;
	logic signed [DataW-1:0]  ffg;
	logic signed [IntegW+1:0] integ_sum;
	logic signed [IntegW-1:0] integ_sat;
	logic signed [AccW-1:0]   acc_add;
	logic signed [AccW-17:0]  acc_shr;
	logic        [OpW-1:0]    mag;
	logic        [TimeW:0]    trial;
	logic                     qbit;
	logic signed [DataW-1:0]  q_sat, negq;

	always_comb begin
		logic signed [OpW-1:0] s;
		s = {tgt_q[DataW-1], tgt_q} - {meas_q[DataW-1], meas_q};
		if (s[OpW-1] != s[OpW-2]) begin
			err_c = s[OpW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
		end else begin
			err_c = s[DataW-1:0];
		end
		dd = {err_c[DataW-1], err_c} - {last_err_q[DataW-1], last_err_q};
	end

	assign ffg = tgt_q[DataW-1] ? cfg.ff_neg : cfg.ff_pos;

	always_comb begin
		unique case (cmd.sel)
			MS_IDT: begin
				op_a = {err_q[DataW-1], err_q};
				op_b = {{(OpW-TimeW){1'b0}}, dt_q};
			end
			MS_FF: begin
				op_a = {tgt_q[DataW-1], tgt_q};
				op_b = {ffg[DataW-1], ffg};
			end
			MS_PROP: begin
				op_a = {cfg.prop[DataW-1], cfg.prop};
				op_b = {err_q[DataW-1], err_q};
			end
			MS_IH: begin
				op_a = {cfg.integ[DataW-1], cfg.integ};
				op_b = {{(OpW-24){integ_q[IntegW-1]}}, integ_q[IntegW-1:24]};
			end
			MS_IL: begin
				op_a = {cfg.integ[DataW-1], cfg.integ};
				op_b = {{(OpW-24){1'b0}}, integ_q[23:0]};
			end
			default: begin
				op_a = {cfg.deriv[DataW-1], cfg.deriv};
				op_b = {deriv_q[DataW-1], deriv_q};
			end
		endcase
	end

	// Integral: floor of err*dt / 2^20 added and saturated to 48 bits.
	always_comb begin
		integ_sum = {{2{integ_q[IntegW-1]}}, integ_q}
			+ {{(IntegW+2-(ProdW-20)){prod_q[ProdW-1]}}, prod_q[ProdW-1:20]};
		if (integ_sum[IntegW+1:IntegW-1] == 3'b000 || integ_sum[IntegW+1:IntegW-1] == 3'b111) begin
			integ_sat = integ_sum[IntegW-1:0];
		end else begin
			integ_sat = integ_sum[IntegW+1] ? {1'b1, {(IntegW-1){1'b0}}}
				: {1'b0, {(IntegW-1){1'b1}}};
		end
	end

	always_comb begin
		acc_add = AccW'(prod_q);
		if (cmd.sel == MS_IH) begin
			acc_add = acc_add <<< 24;
		end
	end
	assign acc_shr = acc_q[AccW-1:16];

	assign mag   = diff_q[OpW-1] ? OpW'(-diff_q) : OpW'(diff_q);
	assign trial = {rem_q, num_q[DivW-1]};
	assign qbit  = (trial >= {1'b0, dt_q});

	always_comb begin
		negq = -$signed(num_q[DataW-1:0]);
		if (dneg_q) begin
			if ((|num_q[DivW-1:DataW]) || (num_q[DataW-1] && (|num_q[DataW-2:0]))) begin
				q_sat = {1'b1, {(DataW-1){1'b0}}};
			end else begin
				q_sat = negq;
			end
		end else begin
			q_sat = (|num_q[DivW-1:DataW-1]) ? {1'b0, {(DataW-1){1'b1}}}
				: num_q[DataW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q  <= speed_ref;
			meas_q <= speed_fb;
			dt_q   <= (step_time == '0) ? DtDefault : step_time;
		end
		if (cmd.calc_err) begin
			err_q  <= err_c;
			diff_q <= dd;
		end
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.div_init) begin
			num_q  <= {mag, {(DivW-OpW){1'b0}}};
			rem_q  <= '0;
			dneg_q <= diff_q[OpW-1];
		end else if (cmd.div_step) begin
			rem_q <= qbit ? TimeW'(trial - {1'b0, dt_q}) : trial[TimeW-1:0];
			num_q <= {num_q[DivW-2:0], qbit};
		end
		if (cmd.integ_upd) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + acc_add;
		end
		if (cmd.deriv_load) begin
			deriv_q <= last_valid_q ? q_sat : '0;
		end
		if (cmd.clear) begin
			res_q <= '0;
		end else if (cmd.clamp) begin
			if (acc_shr > (AccW-16)'(cfg.dmax)) begin
				res_q <= cfg.dmax;
			end else if (acc_shr < (AccW-16)'(cfg.dmin)) begin
				res_q <= cfg.dmin;
			end else begin
				res_q <= acc_shr[DataW-1:0];
			end
		end
		if (cmd.finish) begin
			drive_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q      <= '0;
			last_err_q   <= '0;
			last_valid_q <= 1'b0;
		end else if (cmd.clear) begin
			integ_q      <= '0;
			last_err_q   <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (cmd.integ_upd) begin
				integ_q <= integ_sat;
			end
			if (cmd.deriv_load) begin
				last_err_q   <= err_q;
				last_valid_q <= 1'b1;
			end
		end
	end

	assign stat.target_zero = (tgt_q == '0);
	assign stat.last_valid  = last_valid_q;
	assign drive            = drive_q;
endmodule
`default_nettype wire
